### src/tes_pkg.sv
// Package for the timer event scheduler: sizes, codes, slot entry and compare types.
`timescale 1ns / 1ps
package tes_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int RANK_W = $clog2(SLOTS) + 1;

    typedef enum logic [2:0] {
        REQ_INIT   = 3'd0,
        REQ_ADD    = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_CHANGE = 3'd3,
        REQ_CANCEL = 3'd4,
        REQ_QUERY  = 3'd5,
        REQ_FINISH = 3'd6,
        REQ_TICK   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_EXPIRE = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_RELOAD = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0]       expiry;
        logic [63:0]       gap;
        logic [63:0]       token;
        logic [RANK_W-1:0] rank;
        logic              oneshot;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [63:0] diff;
        logic        eq;
    } t_cmp;

endpackage

### src/tes_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module tes_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/tes_cmp.sv
// Shared 64-bit subtract and equality unit used by every scan and the reload compute.
`timescale 1ns / 1ps
module tes_cmp (
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output tes_pkg::t_cmp o_res
);
    import tes_pkg::*;

    logic [63:0] diff;

    assign diff       = i_a - i_b;
    assign o_res.diff = diff;
    assign o_res.eq   = (diff == 64'd0);
endmodule

### src/timer_event_scheduler.sv
// Timer event scheduler top level: slot flags, sequencer, output register and checks.
// Non-tick requests: a slot read (S_RD, S_RDW), plus an unlink or link scan where needed.
// Tick: repeated first-event scans; each expired event adds an unlink and, if
// re-armed, a link scan. All scans share one slot RAM port and one comparator.
// One item is in work at a time; results wait in an output register.
// Reset (synchronous, active low) clears ready/linked flags and control; no clearing pass.
`timescale 1ns / 1ps
module timer_event_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_slot,
    input  logic [63:0] i_time_value,
    input  logic [63:0] i_period_gap,
    input  logic        i_oneshot_port,
    input  logic [63:0] i_token,
    input  logic        i_deliver_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic [63:0] o_token_out,
    output logic        o_is_linked,
    output logic [63:0] o_reload_gap,
    output logic        o_last
);
    import tes_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_FSCAN, S_LSCAN, S_USCAN, S_TCHK,
        S_TEXP, S_RELOAD, S_EMIT_ST, S_EMIT_CAN
    } t_state;

    t_state            r_state, n_state;
    logic [63:0]       r_idle;
    logic [SLOTS-1:0]  r_ready, n_ready, r_linked, n_linked, r_visited, n_visited;
    t_req              r_req, n_req;
    logic [3:0]        r_slot_in, n_slot_in;
    logic [63:0]       r_tv, n_tv, r_gap, n_gap, r_tok, n_tok, r_lt, n_lt;
    logic              r_port, n_port, r_rdy, n_rdy;
    t_status           r_st, n_st;
    logic              r_isl, n_isl;
    logic [SLOT_W-1:0] r_cs, n_cs, r_pidx, n_pidx, r_bidx, n_bidx;
    t_entry            r_ce, n_ce, r_be, n_be;
    logic              r_bvalid, n_bvalid, r_pval, n_pval;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RANK_W-1:0] r_lcnt, n_lcnt;
    logic [63:0]       r_reload, n_reload;

    logic              r_ov, n_ov, r_olast, n_olast, r_oisl, n_oisl;
    t_kind             r_okind, n_okind;
    t_status           r_ost, n_ost;
    logic [3:0]        r_oslot, n_oslot;
    logic [63:0]       r_otok, n_otok, r_ogap, n_ogap;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, rd;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [63:0]       cmp_a, cmp_b;
    t_cmp              cmp;
    logic              out_free, scan_done, tv_early;
    t_entry            wr_ent;

    tes_ram #(.W(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    tes_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_res(cmp)
    );

    assign rd        = t_entry'(ram_rdata);
    assign out_free  = !r_ov || !i_stall;
    assign scan_done = (r_cnt == CNT_W'(SLOTS)) && !r_pval;
    // tv earlier than the best expiry, from d = expiry - tv
    assign tv_early  = (cmp.diff != 64'd0) && (!cmp.diff[63] || cmp.diff[62:0] == 63'd0);

    always_comb begin
        cmp_a = rd.expiry;
        unique case (r_state)
            S_FSCAN: cmp_b = r_be.expiry;
            S_LSCAN: cmp_b = r_lt;
            S_TCHK:  begin
                cmp_a = r_be.expiry;
                cmp_b = r_tv;
            end
            default: cmp_b = r_ce.expiry;
        endcase
    end

    always_comb begin
        n_state = r_state;   n_ready = r_ready;   n_linked = r_linked;
        n_visited = r_visited; n_req = r_req;     n_slot_in = r_slot_in;
        n_tv = r_tv;  n_gap = r_gap;  n_tok = r_tok;  n_lt = r_lt;
        n_port = r_port;  n_rdy = r_rdy;  n_st = r_st;  n_isl = r_isl;
        n_cs = r_cs;  n_pidx = r_pidx;  n_bidx = r_bidx;  n_ce = r_ce;  n_be = r_be;
        n_bvalid = r_bvalid;  n_pval = r_pval;  n_cnt = r_cnt;  n_lcnt = r_lcnt;
        n_reload = r_reload;
        n_ov = r_ov && i_stall;  n_olast = r_olast;  n_oisl = r_oisl;  n_okind = r_okind;
        n_ost = r_ost;  n_oslot = r_oslot;  n_otok = r_otok;  n_ogap = r_ogap;
        ram_we = 1'b0;  ram_waddr = r_cs;  ram_wdata = r_ce;
        ram_raddr = r_cnt[SLOT_W-1:0];
        wr_ent = r_ce;

        if (r_state == S_FSCAN || r_state == S_LSCAN || r_state == S_USCAN) begin
            if (r_cnt < CNT_W'(SLOTS)) begin
                n_cnt  = r_cnt + CNT_W'(1);
                n_pval = 1'b1;
                n_pidx = r_cnt[SLOT_W-1:0];
            end else begin
                n_pval = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req = t_req'(i_req_type);  n_slot_in = i_slot;
                    n_tv = i_time_value;  n_gap = i_period_gap;  n_port = i_oneshot_port;
                    n_tok = i_token;  n_rdy = i_deliver_ready;
                    n_st = ST_OK;  n_isl = 1'b0;  n_visited = '0;
                    n_cs = SLOT_W'(i_slot);
                    n_cnt = '0;  n_pval = 1'b0;  n_bvalid = 1'b0;  n_lcnt = '0;
                    if (t_req'(i_req_type) == REQ_TICK) begin
                        n_state = S_FSCAN;
                    end else if (32'(i_slot) >= SLOTS) begin
                        n_st = ST_INVALID;
                        n_state = S_EMIT_ST;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                ram_raddr = r_cs;
                n_state = S_RDW;
            end
            S_RDW: begin
                n_ce = rd;
                n_state = S_EMIT_ST;
                unique case (r_req)
                    REQ_INIT: begin
                        if (r_linked[r_cs] || ((r_gap == 64'd0) == !r_port)) begin
                            n_st = ST_INVALID;
                        end else begin
                            wr_ent = rd;
                            wr_ent.gap = r_gap;
                            wr_ent.oneshot = (r_gap == 64'd0);
                            wr_ent.token = r_tok;
                            ram_we = 1'b1;
                            ram_wdata = wr_ent;
                            n_ready[r_cs] = 1'b1;
                        end
                    end
                    REQ_ADD: begin
                        if (r_linked[r_cs] || !r_ready[r_cs]) begin
                            n_st = ST_INVALID;
                        end else begin
                            n_lt = r_tv;
                            n_state = S_LSCAN;
                        end
                    end
                    REQ_DELETE, REQ_CHANGE: begin
                        if (r_linked[r_cs]) n_state = S_USCAN;
                        else n_st = ST_NOT_FOUND;
                    end
                    REQ_CANCEL: begin
                        if (rd.gap != 64'd0 || !r_ready[r_cs]) n_st = ST_INVALID;
                        else if (r_linked[r_cs]) n_state = S_USCAN;
                        else n_state = S_EMIT_CAN;
                    end
                    REQ_QUERY: n_isl = r_linked[r_cs];
                    REQ_FINISH: begin
                        if (rd.gap != 64'd0) n_st = ST_INVALID;
                        else if (r_linked[r_cs]) n_state = S_USCAN;
                        else n_ready[r_cs] = 1'b0;
                    end
                    default: n_state = S_EMIT_ST;
                endcase
            end
            S_FSCAN: begin
                if (r_pval && r_linked[r_pidx] &&
                    (!r_bvalid || cmp.diff[63] || (cmp.eq && rd.rank < r_be.rank))) begin
                    n_bvalid = 1'b1;
                    n_bidx = r_pidx;
                    n_be = rd;
                end
                if (scan_done) n_state = S_TCHK;
            end
            S_LSCAN: begin
                if (r_pval && r_linked[r_pidx] && cmp.eq) n_lcnt = r_lcnt + RANK_W'(1);
                if (scan_done) begin
                    wr_ent = r_ce;
                    wr_ent.expiry = r_lt;
                    wr_ent.rank = r_lcnt;
                    ram_we = 1'b1;
                    ram_wdata = wr_ent;
                    n_linked[r_cs] = 1'b1;
                    n_cnt = '0;  n_pval = 1'b0;  n_bvalid = 1'b0;  n_lcnt = '0;
                    n_state = (r_req == REQ_TICK) ? S_FSCAN : S_EMIT_ST;
                end
            end
            S_USCAN: begin
                // close the gap left in the same-expiry group
                if (r_pval && r_pidx != r_cs && r_linked[r_pidx] && cmp.eq &&
                    rd.rank > r_ce.rank) begin
                    wr_ent = rd;
                    wr_ent.rank = rd.rank - RANK_W'(1);
                    ram_we = 1'b1;
                    ram_waddr = r_pidx;
                    ram_wdata = wr_ent;
                end
                if (scan_done) begin
                    n_linked[r_cs] = 1'b0;
                    n_cnt = '0;  n_pval = 1'b0;  n_bvalid = 1'b0;  n_lcnt = '0;
                    n_state = S_EMIT_ST;
                    unique case (r_req)
                        REQ_CHANGE: begin
                            if (!r_ready[r_cs]) begin
                                n_st = ST_INVALID;
                            end else begin
                                n_lt = r_tv;
                                n_state = S_LSCAN;
                            end
                        end
                        REQ_CANCEL: n_state = S_EMIT_CAN;
                        REQ_FINISH: n_ready[r_cs] = 1'b0;
                        REQ_TICK: begin
                            if (r_ce.gap != 64'd0) begin
                                n_lt = r_tv + r_ce.gap;
                                n_state = S_LSCAN;
                            end else begin
                                n_state = S_TEXP;
                            end
                        end
                        default: n_state = S_EMIT_ST;
                    endcase
                end
            end
            S_TCHK: begin
                n_state = S_RELOAD;
                if (!r_bvalid) begin
                    n_reload = r_idle;
                end else if (tv_early) begin
                    n_reload = cmp.diff;
                end else if (r_visited[r_bidx]) begin
                    n_reload = 64'd1;
                end else begin
                    n_visited[r_bidx] = 1'b1;
                    n_cs = r_bidx;
                    n_ce = r_be;
                    n_cnt = '0;  n_pval = 1'b0;
                    n_state = S_USCAN;
                end
            end
            S_TEXP: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_okind = KIND_EXPIRE;  n_ost = ST_OK;
                    n_oslot = 4'(r_cs);  n_otok = r_ce.token;  n_oisl = 1'b0;
                    n_ogap = 64'd0;  n_olast = 1'b0;
                    n_cnt = '0;  n_pval = 1'b0;  n_bvalid = 1'b0;  n_lcnt = '0;
                    if (r_rdy) begin
                        n_ready[r_cs] = 1'b0;
                        n_state = S_FSCAN;
                    end else begin
                        n_lt = r_tv + 64'd1;
                        n_state = S_LSCAN;
                    end
                end
            end
            S_RELOAD: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_okind = KIND_RELOAD;  n_ost = ST_OK;
                    n_oslot = 4'd0;  n_otok = 64'd0;  n_oisl = 1'b0;
                    n_ogap = r_reload;  n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT_CAN: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_okind = KIND_CANCEL;  n_ost = ST_OK;
                    n_oslot = r_slot_in;  n_otok = r_ce.token;  n_oisl = 1'b0;
                    n_ogap = 64'd0;  n_olast = 1'b0;
                    n_st = ST_OK;
                    n_state = S_EMIT_ST;
                end
            end
            S_EMIT_ST: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_okind = KIND_STATUS;  n_ost = r_st;
                    n_oslot = r_slot_in;  n_otok = 64'd0;  n_oisl = r_isl;
                    n_ogap = 64'd0;  n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idle  <= 64'd1;
            r_ready <= '0;
            r_linked <= '0;
            r_ov    <= 1'b0;
            r_pval  <= 1'b0;
            r_cnt   <= '0;
            r_bvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_idle <= i_cfg_wr_data;
            r_ready <= n_ready;
            r_linked <= n_linked;
            r_ov    <= n_ov;
            r_pval  <= n_pval;
            r_cnt   <= n_cnt;
            r_bvalid <= n_bvalid;
        end
        r_visited <= n_visited;  r_req <= n_req;  r_slot_in <= n_slot_in;
        r_tv <= n_tv;  r_gap <= n_gap;  r_tok <= n_tok;  r_lt <= n_lt;
        r_port <= n_port;  r_rdy <= n_rdy;  r_st <= n_st;  r_isl <= n_isl;
        r_cs <= n_cs;  r_pidx <= n_pidx;  r_bidx <= n_bidx;  r_ce <= n_ce;  r_be <= n_be;
        r_lcnt <= n_lcnt;  r_reload <= n_reload;
        r_olast <= n_olast;  r_oisl <= n_oisl;  r_okind <= n_okind;  r_ost <= n_ost;
        r_oslot <= n_oslot;  r_otok <= n_otok;  r_ogap <= n_ogap;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_result_kind = r_okind;
    assign o_status      = r_ost;
    assign o_slot_out    = r_oslot;
    assign o_token_out   = r_otok;
    assign o_is_linked   = r_oisl;
    assign o_reload_gap  = r_ogap;
    assign o_last        = r_olast;

`ifndef NO_ASSERTIONS
    a_linked_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_linked & ~r_ready) == '0)
        else $error("linked slot without a target");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_STATUS || o_result_kind == KIND_RELOAD)
        |-> o_last)
        else $error("status or reload result not final");
    a_msg_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_EXPIRE || o_result_kind == KIND_CANCEL)
        |-> !o_last)
        else $error("message result marked final");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("transaction accepted without leaving idle");
`endif
endmodule

### bench/tes_checker.sv
// Checker for the timer event scheduler: predicts results from accepted requests and compares.
`timescale 1ns / 1ps
module tes_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_slot,
    input  logic [63:0] i_time_value,
    input  logic [63:0] i_period_gap,
    input  logic        i_oneshot_port,
    input  logic [63:0] i_token,
    input  logic        i_deliver_ready,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_slot_out,
    input  logic [63:0] i_token_out,
    input  logic        i_is_linked,
    input  logic [63:0] i_reload_gap,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    import tes_pkg::*;

    typedef struct {
        t_kind       kind;
        t_status     status;
        logic [3:0]  slot;
        logic [63:0] token;
        logic        linked;
        logic [63:0] gap;
        logic        last;
    } t_result;

    t_result     expected_q[$];
    int          fails = 0;
    logic [63:0] idle_gap = 64'd1;
    logic        ev_ready  [SLOTS];
    logic        ev_linked [SLOTS];
    logic [63:0] ev_gap    [SLOTS];
    logic [63:0] ev_token  [SLOTS];
    logic [63:0] ev_expiry [SLOTS];
    logic [4:0]  ev_rank   [SLOTS];

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            ev_ready[i] = 0; ev_linked[i] = 0; ev_gap[i] = '0;
            ev_token[i] = '0; ev_expiry[i] = '0; ev_rank[i] = '0;
        end
    end

    // wrap-aware: a is before b when a-b is negative
    function automatic bit is_earlier(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return d[63];
    endfunction

    function automatic int next_expiring();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!ev_linked[i]) continue;
            if (best < 0 || is_earlier(ev_expiry[i], ev_expiry[best]) ||
                (ev_expiry[i] == ev_expiry[best] && ev_rank[i] < ev_rank[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic unlink_event(int s);
        for (int j = 0; j < SLOTS; j++)
            if (j != s && ev_linked[j] && ev_expiry[j] == ev_expiry[s] &&
                ev_rank[j] > ev_rank[s])
                ev_rank[j]--;
        ev_linked[s] = 0;
    endtask

    task automatic link_event(int s, logic [63:0] t);
        logic [4:0] r;
        r = '0;
        for (int j = 0; j < SLOTS; j++)
            if (ev_linked[j] && ev_expiry[j] == t) r++;
        ev_expiry[s] = t;
        ev_rank[s]   = r;
        ev_linked[s] = 1;
    endtask

    task automatic push_result(t_kind k, t_status st, logic [3:0] sl, logic [63:0] tok,
                               logic lk, logic [63:0] gp, logic lst);
        t_result r;
        r = '{k, st, sl, tok, lk, gp, lst};
        expected_q.push_back(r);
    endtask

    task automatic add_event(int s, logic [63:0] t, inout t_status st);
        if (ev_linked[s] || !ev_ready[s]) st = ST_INVALID;
        else link_event(s, t);
    endtask

    task automatic predict_request(t_req req, logic [3:0] sl, logic [63:0] tv,
                                   logic [63:0] gp, logic port, logic [63:0] tok,
                                   logic rdy);
        t_status     st;
        int          s, f;
        logic [15:0] visited;
        logic [63:0] reload;
        st = ST_OK;
        s  = int'(sl);
        visited = '0;
        case (req)
            REQ_TICK: begin
                forever begin
                    f = next_expiring();
                    if (f < 0 || is_earlier(tv, ev_expiry[f])) break;
                    if (visited[f]) break;   // gap above 2^63: stop the walk
                    visited[f] = 1;
                    unlink_event(f);
                    if (ev_gap[f] != 0) begin
                        link_event(f, tv + ev_gap[f]);
                    end else begin
                        push_result(KIND_EXPIRE, ST_OK, f[3:0], ev_token[f], 0, '0, 0);
                        if (rdy) ev_ready[f] = 0;
                        else link_event(f, tv + 64'd1);
                    end
                end
                f = next_expiring();
                if (f < 0) reload = idle_gap;
                else if (is_earlier(tv, ev_expiry[f])) reload = ev_expiry[f] - tv;
                else reload = 64'd1;
                push_result(KIND_RELOAD, ST_OK, '0, '0, 0, reload, 1);
                return;
            end
            REQ_INIT: begin
                if (ev_linked[s] || ((gp == 0) == (port == 0))) begin
                    st = ST_INVALID;
                end else begin
                    ev_gap[s] = gp; ev_token[s] = tok; ev_ready[s] = 1;
                end
            end
            REQ_ADD: add_event(s, tv, st);
            REQ_DELETE: begin
                if (ev_linked[s]) unlink_event(s);
                else st = ST_NOT_FOUND;
            end
            REQ_CHANGE: begin
                if (ev_linked[s]) begin
                    unlink_event(s);
                    add_event(s, tv, st);
                end else begin
                    st = ST_NOT_FOUND;
                end
            end
            REQ_CANCEL: begin
                if (ev_gap[s] != 0 || !ev_ready[s]) begin
                    st = ST_INVALID;
                end else begin
                    if (ev_linked[s]) unlink_event(s);
                    push_result(KIND_CANCEL, ST_OK, sl, ev_token[s], 0, '0, 0);
                end
            end
            REQ_QUERY: begin
                push_result(KIND_STATUS, ST_OK, sl, '0, ev_linked[s], '0, 1);
                return;
            end
            default: begin
                if (ev_gap[s] != 0) begin
                    st = ST_INVALID;
                end else begin
                    if (ev_linked[s]) unlink_event(s);
                    ev_ready[s] = 0;
                end
            end
        endcase
        push_result(KIND_STATUS, st, sl, '0, 0, '0, 1);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        fails++;
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result kind", 64'(i_result_kind), 64'd0);
                end else begin
                    w = expected_q.pop_front();
                    if (i_result_kind != w.kind)
                        report_mismatch("kind", 64'(i_result_kind), 64'(w.kind));
                    if (i_status != w.status)
                        report_mismatch("status", 64'(i_status), 64'(w.status));
                    if (i_slot_out != w.slot)
                        report_mismatch("slot", 64'(i_slot_out), 64'(w.slot));
                    if (i_token_out != w.token) report_mismatch("token", i_token_out, w.token);
                    if (i_is_linked != w.linked)
                        report_mismatch("is_linked", 64'(i_is_linked), 64'(w.linked));
                    if (i_reload_gap != w.gap) report_mismatch("reload_gap", i_reload_gap, w.gap);
                    if (i_last != w.last)
                        report_mismatch("last", 64'(i_last), 64'(w.last));
                end
            end
            if (i_cfg_wr_en) idle_gap = i_cfg_wr_data;
            if (i_valid && !i_in_stall)
                predict_request(t_req'(i_req_type), i_slot, i_time_value, i_period_gap,
                                i_oneshot_port, i_token, i_deliver_ready);
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

### bench/tb_timer_event_scheduler.sv
// Testbench top for the timer event scheduler: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_timer_event_scheduler;
    import tes_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_req        req;
        logic [3:0]  slot;
        logic [63:0] tv;
        logic [63:0] gap;
        logic        port;
        logic [63:0] tok;
        logic        rdy;
    } t_request;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [63:0] i_cfg_wr_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_req_type = '0;
    logic [3:0]  i_slot = '0;
    logic [63:0] i_time_value = '0;
    logic [63:0] i_period_gap = '0;
    logic        i_oneshot_port = 0;
    logic [63:0] i_token = '0;
    logic        i_deliver_ready = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_result_kind;
    logic [1:0]  o_status;
    logic [3:0]  o_slot_out;
    logic [63:0] o_token_out;
    logic        o_is_linked;
    logic [63:0] o_reload_gap;
    logic        o_last;
    int          chk_fails, chk_pending;

    logic [63:0] now = '0;
    bit          initialized [SLOTS];
    int          sent = 0, ticks = 0, results_seen = 0, idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    timer_event_scheduler dut (.*);

    tes_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_wr_data, .i_valid,
        .i_in_stall(o_stall), .i_req_type, .i_slot, .i_time_value, .i_period_gap,
        .i_oneshot_port, .i_token, .i_deliver_ready, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_result_kind(o_result_kind), .i_status(o_status),
        .i_slot_out(o_slot_out), .i_token_out(o_token_out), .i_is_linked(o_is_linked),
        .i_reload_gap(o_reload_gap), .i_last(o_last),
        .o_fail_count(chk_fails), .o_pending(chk_pending)
    );

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_request mk(t_req r, int sl, logic [63:0] tv, logic [63:0] gp,
                                    logic port, logic [63:0] tok, logic rdy);
        t_request it;
        it = '{r, sl[3:0], tv, gp, port, tok, rdy};
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) results_seen <= results_seen + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold while requests keep coming
    initial begin
        bit held;
        int p;
        held = 0;
        forever begin
            if (!held && results_seen >= 40) begin
                held = 1;
                i_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                p = $urandom_range(0, 99);
                if (p < 10) begin
                    i_stall <= 0;
                    repeat ($urandom_range(40, 80)) @(posedge i_clk);
                end else begin
                    i_stall <= (p < 45);
                    repeat (pick_gap() + 1) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_request(t_request it);
        int g;
        i_valid         <= 1;
        i_req_type      <= it.req;
        i_slot          <= it.slot;
        i_time_value    <= it.tv;
        i_period_gap    <= it.gap;
        i_oneshot_port  <= it.port;
        i_token         <= it.tok;
        i_deliver_ready <= it.rdy;
        if (it.req == REQ_INIT && ((it.gap == 0) != (it.port == 0)))
            initialized[it.slot] = 1;
        if (it.req == REQ_TICK) ticks++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (3 * SLOTS + 10) @(posedge i_clk);
    endtask

    task automatic write_idle_gap(logic [63:0] v);
        i_cfg_wr_en   <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 0;
    endtask

    task automatic make_random(output t_request it);
        int p, q;
        logic [3:0] s;
        p = $urandom_range(0, 99);
        s = 4'($urandom_range(0, SLOTS - 1));
        // unused fields carry noise
        it = mk(REQ_QUERY, int'(s), rnd64(), rnd64(), 1'($urandom_range(0, 1)), rnd64(),
                1'($urandom_range(0, 1)));
        if (p < 14) begin
            it.req = REQ_INIT;
            q = $urandom_range(0, 9);
            if (q < 5) begin
                it.gap  = (q == 4) ? (rnd64() | 64'd1) : 64'($urandom_range(1, 40));
                it.port = 0;
            end else if (q < 8) begin
                it.gap = '0; it.port = 1;
            end else if (q == 8) begin
                it.gap = 64'($urandom_range(1, 9)); it.port = 1;
            end else begin
                it.gap = '0; it.port = 0;
            end
        end else if (p < 32) begin
            it.req = REQ_ADD;
            it.tv  = ($urandom_range(0, 9) == 0) ? rnd64() : now + 64'($urandom_range(0, 30));
        end else if (p < 38) begin
            it.req = REQ_DELETE;
        end else if (p < 46) begin
            it.req = REQ_CHANGE;
            it.tv  = now + 64'($urandom_range(0, 30));
        end else if (p < 54) begin
            if (initialized[s]) it.req = REQ_CANCEL;
        end else if (p < 60) begin
            if (initialized[s]) it.req = REQ_FINISH;
        end else if (p >= 66) begin
            it.req = REQ_TICK;
            now = ($urandom_range(0, 19) == 0) ? now + rnd64()
                                               : now + 64'($urandom_range(0, 12));
            it.tv  = now;
            it.rdy = ($urandom_range(0, 9) < 7);
        end
    endtask

    initial begin
        t_request    directed [$];
        t_request    it;
        logic [63:0] gap_settings [4];
        gap_settings = '{64'd0, 64'd0, 64'd1, 64'd0};
        gap_settings[1] = rnd64();
        for (int i = 0; i < SLOTS; i++) initialized[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_idle_gap('1);
        directed = '{
            mk(REQ_TICK,   0, 64'd0, '0, 0, '0, 1),          // nothing linked: idle gap
            mk(REQ_INIT,   0, '0, 64'd10, 0, '0, 0),
            mk(REQ_INIT,   1, '0, '0, 1, '1, 0),
            mk(REQ_INIT,   2, '0, '0, 0, '0, 0),             // neither gap nor port
            mk(REQ_INIT,   3, '0, '1, 1, '0, 0),             // both set
            mk(REQ_ADD,    0, 64'd5, '0, 0, '0, 0),
            mk(REQ_ADD,    1, 64'd5, '0, 0, '0, 0),          // same expiry, queued behind
            mk(REQ_ADD,    2, 64'd5, '0, 0, '0, 0),          // not ready
            mk(REQ_ADD,    0, 64'd7, '0, 0, '0, 0),          // already linked
            mk(REQ_INIT,   0, '0, 64'd3, 0, '0, 0),          // init on linked slot
            mk(REQ_QUERY, 15, '0, '0, 0, '0, 0),
            mk(REQ_QUERY,  0, '0, '0, 0, '0, 0),
            mk(REQ_TICK,   0, 64'd5, '0, 0, '0, 0),          // receiver not ready
            mk(REQ_TICK,   0, 64'd6, '0, 0, '0, 1),
            mk(REQ_CHANGE, 0, 64'd100, '0, 0, '0, 0),
            mk(REQ_DELETE, 3, '0, '0, 0, '0, 0),
            mk(REQ_CHANGE, 3, 64'd9, '0, 0, '0, 0),
            mk(REQ_CANCEL, 1, '0, '0, 0, '0, 0),
            mk(REQ_CANCEL, 0, '0, '0, 0, '0, 0),
            mk(REQ_FINISH, 0, '0, '0, 0, '0, 0),
            mk(REQ_FINISH, 1, '0, '0, 0, '0, 0),
            mk(REQ_INIT,  15, '0, '1, 0, '1, 0),             // gap all ones: walk bound
            mk(REQ_ADD,   15, '1, '0, 0, '0, 0),
            mk(REQ_TICK,   0, 64'd0, '0, 0, '0, 1),
            mk(REQ_DELETE, 0, '0, '0, 0, '0, 0)
        };
        foreach (directed[i]) send_request(directed[i]);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_idle_gap(gap_settings[ph]);
            if (ph == 2) now = 64'hFFFF_FFFF_FFFF_FF80;   // cross the time wrap
            repeat (47) begin
                make_random(it);
                send_request(it);
            end
            if (ph == 1) begin
                // empty the queue so the idle gap shows up
                for (int s = 0; s < SLOTS; s++)
                    send_request(mk(REQ_DELETE, s, '0, '0, 0, '0, 0));
                send_request(mk(REQ_TICK, 0, now, '0, 0, '0, 1));
            end
            wait_drained();
        end

        $display("Sent %0d requests (%0d ticks), %0d results checked, 5 reload-gap settings,",
                 sent, ticks, results_seen);
        $display("including ties, rejected requests, a time wrap and a long result hold.");
        if (chk_fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", chk_fails);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### timer_event_scheduler.f
src/tes_pkg.sv
src/tes_ram.sv
src/tes_cmp.sv
src/timer_event_scheduler.sv
bench/tes_checker.sv
bench/tb_timer_event_scheduler.sv
